// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define PLS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define PLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/pls_pkg.sv -----
// Shared types and constants for the positional list store.
// No dependencies.
package pls_pkg;

  localparam int unsigned DEPTH_DEF  = 64;
  localparam int unsigned DATA_W_DEF = 32;

  localparam int unsigned POS_W   = 7;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 7;

  // action codes
  localparam logic [2:0] ACT_APPEND = 3'd0;
  localparam logic [2:0] ACT_PUT    = 3'd1;
  localparam logic [2:0] ACT_GET    = 3'd2;
  localparam logic [2:0] ACT_LAST   = 3'd3;
  localparam logic [2:0] ACT_REMOVE = 3'd4;
  localparam logic [2:0] ACT_INSERT = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]         action;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value_in;
  } in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value_out;
    logic [COUNT_W-1:0] count_out;
    logic [1:0]         status;
  } out_t;

endpackage

// ----- rtl/pls_ram.sv -----
// Entry storage: one write port, one read port, registered read data.
// No dependencies.
module pls_ram #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned DATA_W = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/pls_ctrl.sv -----
// Operation sequencer: decodes one item, walks the shift through the RAM,
// keeps the entry count. Depends on pls_pkg.
module pls_ctrl #(
  parameter int unsigned DEPTH  = pls_pkg::DEPTH_DEF,
  parameter int unsigned DATA_W = pls_pkg::DATA_W_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  pls_pkg::in_t             in_data_i,
  output logic                     in_stall_o,
  output logic                     res_valid_o,
  output pls_pkg::out_t            res_o,
  input  logic                     res_ready_i,
  output logic                     ram_we_o,
  output logic [$clog2(DEPTH)-1:0] ram_waddr_o,
  output logic [DATA_W-1:0]        ram_wdata_o,
  output logic                     ram_re_o,
  output logic [$clog2(DEPTH)-1:0] ram_raddr_o,
  input  logic [DATA_W-1:0]        ram_rdata_i
);

  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > pls_pkg::POS_W) ? CNT_W : pls_pkg::POS_W;
  localparam int unsigned WIDE_W = 64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_RM_FIRST,
    S_RM_SHIFT,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DONE
  } state_e;

  state_e                      state_q, state_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [CNT_W-1:0]            rptr_q, rptr_d;
  logic [CNT_W-1:0]            wptr_q, wptr_d;
  logic [ADDR_W-1:0]           pos_q, pos_d;
  logic [DATA_W-1:0]           val_q, val_d;
  logic [pls_pkg::VALUE_W-1:0] value_q, value_d;
  logic [1:0]                  status_q, status_d;

  logic [CMP_W-1:0]            pos_c, cnt_c;
  logic                        pos_lt, pos_eq, full, empty;
  logic [CNT_W-1:0]            cnt_m1, ptr_m1, ptr_p1;
  logic [WIDE_W-1:0]           vin_w, rd_w;
  logic [DATA_W-1:0]           vin;
  logic [pls_pkg::VALUE_W-1:0] rd_val;

  assign pos_c  = CMP_W'(in_data_i.position);
  assign cnt_c  = CMP_W'(count_q);
  assign pos_lt = pos_c < cnt_c;
  assign pos_eq = pos_c == cnt_c;
  assign full   = count_q == CNT_W'(DEPTH);
  assign empty  = count_q == '0;
  assign cnt_m1 = count_q - CNT_W'(1);
  assign ptr_m1 = rptr_q - CNT_W'(1);
  assign ptr_p1 = rptr_q + CNT_W'(1);
  assign vin_w  = WIDE_W'(in_data_i.value_in);
  assign vin    = vin_w[DATA_W-1:0];
  assign rd_w   = WIDE_W'(ram_rdata_i);
  assign rd_val = rd_w[pls_pkg::VALUE_W-1:0];

  assign in_stall_o      = state_q != S_IDLE;
  assign res_valid_o     = state_q == S_DONE;
  assign res_o.value_out = value_q;
  assign res_o.count_out = cnt_c[pls_pkg::COUNT_W-1:0];
  assign res_o.status    = status_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rptr_d      = rptr_q;
    wptr_d      = wptr_q;
    pos_d       = pos_q;
    val_d       = val_q;
    value_d     = value_q;
    status_d    = status_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = wptr_q[ADDR_W-1:0];
    ram_wdata_o = ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = rptr_q[ADDR_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          value_d  = '0;
          status_d = pls_pkg::ST_OK;
          state_d  = S_DONE;
          case (in_data_i.action)
            pls_pkg::ACT_APPEND: begin
              if (full) begin
                status_d = pls_pkg::ST_FULL;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = count_q[ADDR_W-1:0];
                ram_wdata_o = vin;
                count_d     = count_q + CNT_W'(1);
              end
            end
            pls_pkg::ACT_PUT: begin
              if (pos_lt) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = pos_c[ADDR_W-1:0];
                ram_wdata_o = vin;
              end else if (!pos_eq) begin
                status_d = pls_pkg::ST_BAD;
              end else if (full) begin
                status_d = pls_pkg::ST_FULL;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = count_q[ADDR_W-1:0];
                ram_wdata_o = vin;
                count_d     = count_q + CNT_W'(1);
              end
            end
            pls_pkg::ACT_GET: begin
              if (!pos_lt) begin
                status_d = pls_pkg::ST_BAD;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = pos_c[ADDR_W-1:0];
                state_d     = S_READ;
              end
            end
            pls_pkg::ACT_LAST: begin
              if (empty) begin
                status_d = pls_pkg::ST_BAD;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = cnt_m1[ADDR_W-1:0];
                state_d     = S_READ;
              end
            end
            pls_pkg::ACT_REMOVE: begin
              if (!pos_lt) begin
                status_d = pls_pkg::ST_BAD;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = pos_c[ADDR_W-1:0];
                wptr_d      = pos_c[CNT_W-1:0];
                rptr_d      = pos_c[CNT_W-1:0] + CNT_W'(1);
                state_d     = S_RM_FIRST;
              end
            end
            pls_pkg::ACT_INSERT: begin
              if (!pos_lt) begin
                status_d = pls_pkg::ST_BAD;
              end else if (full) begin
                status_d = pls_pkg::ST_FULL;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = cnt_m1[ADDR_W-1:0];
                rptr_d      = cnt_m1;
                pos_d       = pos_c[ADDR_W-1:0];
                val_d       = vin;
                state_d     = S_INS_SHIFT;
              end
            end
            default: begin
              status_d = pls_pkg::ST_BAD;
            end
          endcase
        end
      end
      S_READ: begin
        value_d = rd_val;
        state_d = S_DONE;
      end
      S_RM_FIRST, S_RM_SHIFT: begin
        // read data is the removed word first, then each word moving down
        if (state_q == S_RM_FIRST) begin
          value_d = rd_val;
        end else begin
          ram_we_o = 1'b1;
          wptr_d   = wptr_q + CNT_W'(1);
        end
        if (rptr_q < count_q) begin
          ram_re_o = 1'b1;
          rptr_d   = ptr_p1;
          state_d  = S_RM_SHIFT;
        end else begin
          count_d = cnt_m1;
          state_d = S_DONE;
        end
      end
      S_INS_SHIFT: begin
        // word read from rptr moves up one place
        ram_we_o    = 1'b1;
        ram_waddr_o = ptr_p1[ADDR_W-1:0];
        if (rptr_q > CNT_W'(pos_q)) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = ptr_m1[ADDR_W-1:0];
          rptr_d      = ptr_m1;
        end else begin
          state_d = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_q;
        ram_wdata_o = val_q;
        count_d     = count_q + CNT_W'(1);
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rptr_q   <= '0;
      wptr_q   <= '0;
      pos_q    <= '0;
      val_q    <= '0;
      value_q  <= '0;
      status_q <= pls_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rptr_q   <= rptr_d;
      wptr_q   <= wptr_d;
      pos_q    <= pos_d;
      val_q    <= val_d;
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

endmodule

// ----- rtl/positional_list_store.sv -----
// Positional list store top level: sequencer, entry RAM, output register.
// Each item: the sequencer decodes it, walks any get, last, remove or insert through
// the RAM, then hands the result to the output register; append, put and failures skip the walk.
// One item at a time: the next item is taken only after the current result has been
// handed to the output register.
// Reset (async, active low) empties the list; entries stay undefined until written.
module positional_list_store #(
  parameter int unsigned DEPTH  = pls_pkg::DEPTH_DEF,
  parameter int unsigned DATA_W = pls_pkg::DATA_W_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pls_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pls_pkg::out_t out_data_o
);

  localparam int unsigned ADDR_W = $clog2(DEPTH);

  // sequencer <-> output register
  logic          res_valid;
  logic          res_ready;
  pls_pkg::out_t res;

  // sequencer <-> RAM
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  // output register
  logic          out_valid_q, out_valid_d;
  pls_pkg::out_t out_q;
  logic          load;

  pls_ctrl #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  pls_ram #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output slot is free when empty or being drained this cycle, so the
  // sequencer can hand over a new result while the old transfer completes.
  assign res_ready = !out_valid_q || !out_stall_i;
  assign load      = res_valid && res_ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload: no reset needed, qualified by out_valid_q
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/pls_checker.sv -----
// Port-level checks for positional_list_store, attached by bind.
// Depends on pls_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pls_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input pls_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input pls_pkg::out_t out_data_o
);

  logic in_xfer;

  assign in_xfer = in_valid_i && !in_stall_o && (in_data_i.action == in_data_i.action);

  `PLS_ASSERT(a_status_legal, clk_i, rst_ni, out_valid_o |-> (out_data_o.status == pls_pkg::ST_OK || out_data_o.status == pls_pkg::ST_BAD || out_data_o.status == pls_pkg::ST_FULL), "illegal status code")
  `PLS_ASSERT(a_fail_zero, clk_i, rst_ni, (out_valid_o && out_data_o.status != pls_pkg::ST_OK) |-> (out_data_o.value_out == '0), "failed op returned nonzero word")
  `PLS_ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, in_xfer, in_stall_o, "input not stalled after transfer")
  `PLS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

endmodule

bind positional_list_store pls_checker u_pls_checker (.*);
